/* sv/lbm_pkg.sv */
// Shared types, constants and helper functions of the D2Q9 BGK collision pipeline.
`timescale 1ns / 1ps
package lbm_pkg;

  localparam int FRAC_BITS = 28;
  localparam int NDIR      = 9;
  localparam int W         = 32;
  localparam int CFG_W     = 29;
  // Scaled dividend width and quotient bits produced by the divider
  localparam int NW        = W + FRAC_BITS;
  localparam int QW        = 33;
  // Wide signed intermediate, holds one, 9*cu2 and shifted products
  localparam int XW        = 48;

  localparam logic [CFG_W-1:0] RELAX_RESET = CFG_W'(268435456);

  localparam logic signed [W-1:0]  S32_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  S32_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [XW-1:0] XMAX    = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] XMIN    = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [XW-1:0] ONE_X   = XW'(1) << FRAC_BITS;

  // Lattice directions
  localparam int DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

  typedef logic signed [W-1:0] word_t;
  typedef word_t [NDIR-1:0]    pops_t;

  typedef struct packed {
    pops_t f;
    logic  solid;
  } cell_t;

  typedef struct packed {
    word_t velocity_y;
    word_t velocity_x;
    word_t density;
    pops_t pop;
  } res_t;

  // Clamp a wide signed value to the 32-bit range
  function automatic word_t sat32(input logic signed [XW-1:0] v);
    word_t r;
    if (v > XMAX) begin
      r = S32_MAX;
    end else if (v < XMIN) begin
      r = S32_MIN;
    end else begin
      r = W'(v);
    end
    return r;
  endfunction

  // Velocity component times a lattice coordinate of -1, 0 or +1
  function automatic logic signed [XW-1:0] dir_term(input int c, input word_t u);
    logic signed [XW-1:0] e;
    e = u;
    if (c > 0) begin
      return e;
    end else if (c < 0) begin
      return -e;
    end else begin
      return '0;
    end
  endfunction

  // Eight steps of long division by nine; returns {remainder, quotient bits}
  function automatic logic [11:0] div9_chunk(input logic [3:0] rem, input logic [7:0] bits);
    logic [4:0] r;
    logic [3:0] rr;
    logic [7:0] qb;
    rr = rem;
    qb = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {rr, bits[i]};
      if (r >= 5'd9) begin
        r = r - 5'd9;
        qb[i] = 1'b1;
      end
      rr = r[3:0];
    end
    return {rr, qb};
  endfunction

endpackage

/* sv/lbm_moments.sv */
// Density and momentum sums of one cell, two register stages.
`timescale 1ns / 1ps
module lbm_moments (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ce,
  input  logic          in_valid,
  input  lbm_pkg::cell_t in_cell,
  output logic          out_valid,
  output lbm_pkg::cell_t out_cell,
  output lbm_pkg::word_t out_rho,
  output lbm_pkg::word_t out_mx,
  output lbm_pkg::word_t out_my
);
  import lbm_pkg::*;

  typedef logic signed [W+1:0] part_t;

  logic  v0_r, v1_r;
  cell_t cell0_r, cell1_r;
  part_t rg_r [3];
  part_t xg_r [3];
  part_t yg_r [3];
  word_t rho_r, mx_r, my_r;

  function automatic part_t ext(input word_t a);
    part_t e;
    e = a;
    return e;
  endfunction

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (ce) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
    end
  end

  // Group sums, then totals with saturation
  always_ff @(posedge clk) begin
    if (ce) begin
      cell0_r <= in_cell;
      rg_r[0] <= ext(in_cell.f[0]) + ext(in_cell.f[1]) + ext(in_cell.f[2]);
      rg_r[1] <= ext(in_cell.f[3]) + ext(in_cell.f[4]) + ext(in_cell.f[5]);
      rg_r[2] <= ext(in_cell.f[6]) + ext(in_cell.f[7]) + ext(in_cell.f[8]);
      xg_r[0] <= ext(in_cell.f[1]) - ext(in_cell.f[3]);
      xg_r[1] <= ext(in_cell.f[5]) - ext(in_cell.f[6]);
      xg_r[2] <= ext(in_cell.f[8]) - ext(in_cell.f[7]);
      yg_r[0] <= ext(in_cell.f[2]) - ext(in_cell.f[4]);
      yg_r[1] <= ext(in_cell.f[5]) + ext(in_cell.f[6]);
      yg_r[2] <= -ext(in_cell.f[7]) - ext(in_cell.f[8]);

      cell1_r <= cell0_r;
      rho_r   <= sat32(XW'(rg_r[0]) + XW'(rg_r[1]) + XW'(rg_r[2]));
      mx_r    <= sat32(XW'(xg_r[0]) + XW'(xg_r[1]) + XW'(xg_r[2]));
      my_r    <= sat32(XW'(yg_r[0]) + XW'(yg_r[1]) + XW'(yg_r[2]));
    end
  end

  assign out_valid = v1_r;
  assign out_cell  = cell1_r;
  assign out_rho   = rho_r;
  assign out_mx    = mx_r;
  assign out_my    = my_r;

endmodule

/* sv/lbm_div.sv */
// Pipelined restoring divider: velocity = momentum * 2^FRAC_BITS / density, one bit a stage.
`timescale 1ns / 1ps
module lbm_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ce,
  input  logic           in_valid,
  input  lbm_pkg::cell_t in_cell,
  input  lbm_pkg::word_t in_rho,
  input  lbm_pkg::word_t in_mx,
  input  lbm_pkg::word_t in_my,
  output logic           out_valid,
  output lbm_pkg::cell_t out_cell,
  output lbm_pkg::word_t out_rho,
  output lbm_pkg::word_t out_ux,
  output lbm_pkg::word_t out_uy
);
  import lbm_pkg::*;

  typedef struct packed {
    logic          neg;
    logic          mpos;
    logic          mneg;
    logic          ovf;
    logic [QW-1:0] rem;
    logic [QW-1:0] nlo;
    logic [QW-1:0] q;
  } lane_t;

  logic         v_r    [QW+1];
  cell_t        cell_r [QW+1];
  word_t        rho_r  [QW+1];
  logic         rz_r   [QW+1];
  logic [W-1:0] b_r    [QW+1];
  lane_t        ln_r   [QW+1][2];

  logic  vf_r;
  cell_t cellf_r;
  word_t rhof_r;
  word_t u_r [2];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) v_r[k] <= 1'b0;
      vf_r <= 1'b0;
    end else if (ce) begin
      v_r[0] <= in_valid;
      for (int k = 1; k <= QW; k++) v_r[k] <= v_r[k-1];
      vf_r <= v_r[QW];
    end
  end

  // Setup stage: magnitudes, signs and the early overflow test
  always_ff @(posedge clk) begin
    logic signed [W:0]  re, me;
    logic [W-1:0]       b, a;
    logic [NW-1:0]      n, hi;
    word_t              m;
    if (ce) begin
      re = in_rho;
      b  = re[W] ? W'(-re) : W'(re);
      cell_r[0] <= in_cell;
      rho_r[0]  <= in_rho;
      rz_r[0]   <= (in_rho == '0);
      b_r[0]    <= b;
      for (int l = 0; l < 2; l++) begin
        m  = (l == 0) ? in_mx : in_my;
        me = m;
        a  = me[W] ? W'(-me) : W'(me);
        n  = {a, {FRAC_BITS{1'b0}}};
        hi = n >> QW;
        ln_r[0][l].neg  <= (m < 0) != (in_rho < 0);
        ln_r[0][l].mpos <= (m > 0);
        ln_r[0][l].mneg <= (m < 0);
        ln_r[0][l].ovf  <= (hi >= {{(NW-W){1'b0}}, b});
        ln_r[0][l].rem  <= QW'(hi);
        ln_r[0][l].nlo  <= n[QW-1:0];
        ln_r[0][l].q    <= '0;
      end
    end
  end

  // One quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_step
    always_ff @(posedge clk) begin
      logic [QW-1:0] r;
      lane_t         p;
      if (ce) begin
        cell_r[k] <= cell_r[k-1];
        rho_r[k]  <= rho_r[k-1];
        rz_r[k]   <= rz_r[k-1];
        b_r[k]    <= b_r[k-1];
        for (int l = 0; l < 2; l++) begin
          p = ln_r[k-1][l];
          r = {p.rem[QW-2:0], p.nlo[QW-1]};
          p.nlo = {p.nlo[QW-2:0], 1'b0};
          if (r >= {1'b0, b_r[k-1]}) begin
            p.rem = r - {1'b0, b_r[k-1]};
            p.q   = {p.q[QW-2:0], 1'b1};
          end else begin
            p.rem = r;
            p.q   = {p.q[QW-2:0], 1'b0};
          end
          ln_r[k][l] <= p;
        end
      end
    end
  end

  // Apply sign, saturate, and handle zero density
  always_ff @(posedge clk) begin
    logic [QW-1:0] lim;
    lane_t         p;
    if (ce) begin
      cellf_r <= cell_r[QW];
      rhof_r  <= rho_r[QW];
      for (int l = 0; l < 2; l++) begin
        p   = ln_r[QW][l];
        lim = p.neg ? {2'b01, {(QW-2){1'b0}}} : {2'b00, {(QW-2){1'b1}}};
        if (rz_r[QW]) begin
          u_r[l] <= p.mpos ? S32_MAX : (p.mneg ? S32_MIN : '0);
        end else if (p.ovf || (p.q > lim)) begin
          u_r[l] <= p.neg ? S32_MIN : S32_MAX;
        end else begin
          u_r[l] <= p.neg ? W'(-p.q) : W'(p.q);
        end
      end
    end
  end

  assign out_valid = vf_r;
  assign out_cell  = cellf_r;
  assign out_rho   = rhof_r;
  assign out_ux    = u_r[0];
  assign out_uy    = u_r[1];

endmodule

/* sv/lbm_equil.sv */
// Equilibrium and BGK relaxation of the nine populations, twelve register stages.
`timescale 1ns / 1ps
module lbm_equil (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     ce,
  input  logic [lbm_pkg::CFG_W-1:0] omega,
  input  logic                     in_valid,
  input  lbm_pkg::cell_t           in_cell,
  input  lbm_pkg::word_t           in_rho,
  input  lbm_pkg::word_t           in_ux,
  input  lbm_pkg::word_t           in_uy,
  output logic                     out_valid,
  output lbm_pkg::res_t            out_res
);
  import lbm_pkg::*;

  localparam int NS = 12;
  localparam int NC = 5;
  localparam int UW = 8 * NC;
  localparam int PW = 2 * W;
  localparam int RW = W + XW - 12;
  // Offset that keeps the dividend of the divide-by-nine positive
  localparam logic signed [XW-1:0] NINE_OFS = XW'(9) << (W + 1);
  localparam logic signed [XW-1:0] Q_OFS    = XW'(1) << (W + 1);

  logic  v_r    [NS];
  cell_t cell_r [NS];
  word_t rho_r  [NS];
  word_t ux_r   [NS];
  word_t uy_r   [NS];

  logic signed [PW-1:0] pxx_r, pyy_r;
  word_t                usq_r;
  word_t                cu_r   [NDIR];
  word_t                cu1_r  [NDIR];
  logic signed [PW-1:0] cpr_r  [NDIR];
  word_t                poly_r [NDIR];
  logic signed [PW-1:0] tp_r   [NDIR];
  logic [UW-1:0]        u_r    [NDIR];
  logic [UW-1:0]        ud_r   [NC][NDIR];
  logic [3:0]           rm_r   [NC][NDIR];
  logic [UW-1:0]        qt_r   [NC][NDIR];
  logic signed [RW-1:0] prod_r [NDIR];
  res_t                 res_r;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) v_r[k] <= 1'b0;
    end else if (ce) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) v_r[k] <= v_r[k-1];
    end
  end

  // Carry the cell, density and velocity down the stages
  always_ff @(posedge clk) begin
    if (ce) begin
      cell_r[0] <= in_cell;
      rho_r[0]  <= in_rho;
      ux_r[0]   <= in_ux;
      uy_r[0]   <= in_uy;
      for (int k = 1; k < NS; k++) begin
        cell_r[k] <= cell_r[k-1];
        rho_r[k]  <= rho_r[k-1];
        ux_r[k]   <= ux_r[k-1];
        uy_r[k]   <= uy_r[k-1];
      end
    end
  end

  // Squared speed: products, then shift and sum
  always_ff @(posedge clk) begin
    if (ce) begin
      pxx_r <= in_ux * in_ux;
      pyy_r <= in_uy * in_uy;
      usq_r <= sat32(XW'(pxx_r >>> FRAC_BITS) + XW'(pyy_r >>> FRAC_BITS));
    end
  end

  for (genvar q = 0; q < NDIR; q++) begin : g_dir
    // Projected velocity, its square, and the polynomial
    always_ff @(posedge clk) begin
      logic signed [XW-1:0] cu, cu2, p;
      if (ce) begin
        cu_r[q]  <= sat32(dir_term(DIR_X[q], in_ux) + dir_term(DIR_Y[q], in_uy));
        cpr_r[q] <= cu_r[q] * cu_r[q];
        cu1_r[q] <= cu_r[q];
        cu  = cu1_r[q];
        cu2 = sat32(XW'(cpr_r[q] >>> FRAC_BITS));
        p   = ONE_X + 3 * cu + ((9 * cu2) >>> 1) - ((3 * XW'(usq_r)) >>> 1);
        poly_r[q] <= sat32(p);
        tp_r[q]   <= rho_r[2] * poly_r[q];
      end
    end

    // Scale by four, one or a quarter for the weight and offset for the divide-by-nine
    always_ff @(posedge clk) begin
      logic signed [XW-1:0] t, y;
      if (ce) begin
        t = sat32(XW'(tp_r[q] >>> FRAC_BITS));
        if (q == 0) begin
          y = t <<< 2;
        end else if (q < 5) begin
          y = t;
        end else begin
          y = t >>> 2;
        end
        u_r[q] <= UW'(y + NINE_OFS);
      end
    end

    // Divide by nine, eight bits a stage
    for (genvar c = 0; c < NC; c++) begin : g_chunk
      logic [UW-1:0] src, qprev;
      logic [3:0]    rprev;

      // Select the dividend and partial results of the previous stage
      if (c == 0) begin : g_head
        assign src   = u_r[q];
        assign rprev = '0;
        assign qprev = '0;
      end else begin : g_tail
        assign src   = ud_r[c-1][q];
        assign rprev = rm_r[c-1][q];
        assign qprev = qt_r[c-1][q];
      end

      always_ff @(posedge clk) begin
        logic [11:0] st;
        if (ce) begin
          st = div9_chunk(rprev, src[UW-1-8*c -: 8]);
          ud_r[c][q] <= src;
          rm_r[c][q] <= st[11:8];
          qt_r[c][q] <= {qprev[UW-9:0], st[7:0]};
        end
      end
    end

    // Relax toward equilibrium and drop solid cells through unchanged
    always_ff @(posedge clk) begin
      logic signed [XW-1:0] feq, diff, f;
      logic signed [W:0]    om;
      if (ce) begin
        f    = $signed(cell_r[9].f[q]);
        feq  = $signed({{(XW-UW){1'b0}}, qt_r[NC-1][q]}) - Q_OFS;
        diff = feq - f;
        om   = $signed({{(W+1-CFG_W){1'b0}}, omega});
        // The difference stays within 34 signed bits
        prod_r[q] <= RW'(om * $signed(diff[W+1:0]));
        f    = $signed(cell_r[10].f[q]);
        if (cell_r[10].solid) begin
          res_r.pop[q] <= cell_r[10].f[q];
        end else begin
          res_r.pop[q] <= sat32(f + XW'(prod_r[q] >>> FRAC_BITS));
        end
      end
    end
  end

  // Density and velocity of the result word
  always_ff @(posedge clk) begin
    if (ce) begin
      if (cell_r[10].solid) begin
        res_r.density    <= sat32(ONE_X);
        res_r.velocity_x <= '0;
        res_r.velocity_y <= '0;
      end else begin
        res_r.density    <= rho_r[10];
        res_r.velocity_x <= ux_r[10];
        res_r.velocity_y <= uy_r[10];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_res   = res_r;

endmodule

/* sv/d2q9_bgk_cell_collision.sv */
// Each accepted input word passes the moments, divider and equilibrium stages to its result word.
// Throughput: one cell per cycle; the 35-stage velocity divider (33 quotient bits) sets the depth.
// The whole pipeline holds while a result word waits on out_tready.
// Reset (rst_n low, synchronous): all valid bits clear, inv_relax_time returns to 1.0.
// Top level of the D2Q9 BGK collision pipeline.
`timescale 1ns / 1ps
module d2q9_bgk_cell_collision (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [lbm_pkg::CFG_W-1:0]    cfg_wr_data,   // inv_relax_time
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // pop_rest, pop_east, pop_north, pop_west, pop_south, pop_northeast,
  // pop_northwest, pop_southwest, pop_southeast
  input  logic [lbm_pkg::NDIR*32-1:0]  in_tdata,
  input  logic                         in_tuser,      // is_solid
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // new_rest .. new_southeast, density, velocity_x, velocity_y
  output logic [(lbm_pkg::NDIR+3)*32-1:0] out_tdata
);
  import lbm_pkg::*;

  logic [CFG_W-1:0] omega_r;
  logic             ce;
  cell_t            cell_in;

  logic  m_valid, d_valid, e_valid;
  cell_t m_cell, d_cell;
  word_t m_rho, m_mx, m_my, d_rho, d_ux, d_uy;
  res_t  e_res;

  // Hold the relaxation register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      omega_r <= RELAX_RESET;
    end else if (cfg_wr_en) begin
      omega_r <= cfg_wr_data;
    end
  end

  // Advance the pipeline unless a result word is held
  assign ce        = !e_valid || out_tready;
  assign in_tready = ce;

  assign cell_in.f     = in_tdata;
  assign cell_in.solid = in_tuser;

  lbm_moments u_moments (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (in_tvalid),
    .in_cell  (cell_in),
    .out_valid(m_valid),
    .out_cell (m_cell),
    .out_rho  (m_rho),
    .out_mx   (m_mx),
    .out_my   (m_my)
  );

  lbm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (m_valid),
    .in_cell  (m_cell),
    .in_rho   (m_rho),
    .in_mx    (m_mx),
    .in_my    (m_my),
    .out_valid(d_valid),
    .out_cell (d_cell),
    .out_rho  (d_rho),
    .out_ux   (d_ux),
    .out_uy   (d_uy)
  );

  lbm_equil u_equil (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .omega    (omega_r),
    .in_valid (d_valid),
    .in_cell  (d_cell),
    .in_rho   (d_rho),
    .in_ux    (d_ux),
    .in_uy    (d_uy),
    .out_valid(e_valid),
    .out_res  (e_res)
  );

  assign out_tvalid = e_valid;
  assign out_tdata  = e_res;

`ifndef ASSERT_OFF
  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  // Zero density gives only saturated or zero velocities
  a_zero_rho_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[319:288] == 32'd0) |->
      ((out_tdata[351:320] == S32_MAX || out_tdata[351:320] == S32_MIN ||
        out_tdata[351:320] == 32'd0) &&
       (out_tdata[383:352] == S32_MAX || out_tdata[383:352] == S32_MIN ||
        out_tdata[383:352] == 32'd0)))
    else $error("unsaturated velocity at zero density");
`endif

endmodule

/* dv/d2q9_bgk_cell_collision_test.sv */
// Self-checking testbench for the D2Q9 BGK cell collision pipeline.
`timescale 1ns / 1ps

// Holds expected collision results and compares them with the output words
class collision_scoreboard;
  typedef logic [(lbm_pkg::NDIR+3)*32-1:0] result_bits_t;

  result_bits_t pending_results[$];
  logic [lbm_pkg::CFG_W-1:0] relax_rate;
  int errors;

  function new();
    relax_rate = lbm_pkg::RELAX_RESET;
    errors = 0;
  endfunction

  function void set_relax(input logic [lbm_pkg::CFG_W-1:0] v);
    relax_rate = v;
  endfunction

  static function longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  static function longint fdiv(input longint v, input longint d);
    longint q;
    q = v / d;
    if ((v % d) != 0 && v < 0) q = q - 1;
    return q;
  endfunction

  // Fixed-point product rounded toward minus infinity
  static function longint fx_mul(input longint a, input longint b);
    return (a * b) >>> lbm_pkg::FRAC_BITS;
  endfunction

  // Momentum over density by restoring division, saturating on overflow
  static function longint fx_div(input longint m, input longint r);
    bit neg;
    longint unsigned a, b, q, rem, lim;
    if (r == 0) begin
      if (m > 0) return 64'sd2147483647;
      if (m < 0) return -64'sd2147483648;
      return 0;
    end
    neg = (m < 0) != (r < 0);
    a = (m < 0) ? -m : m;
    b = (r < 0) ? -r : r;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    q = a / b;
    rem = a % b;
    if (q > lim) return neg ? -64'sd2147483648 : 64'sd2147483647;
    for (int i = 0; i < lbm_pkg::FRAC_BITS; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= b) begin
        rem = rem - b;
        q = q | 1;
      end
      if (q > lim) return neg ? -64'sd2147483648 : 64'sd2147483647;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Compute the collision result of one accepted cell word
  function void note_cell(input logic [lbm_pkg::NDIR*32-1:0] pops, input logic solid);
    longint f[lbm_pkg::NDIR];
    longint one, rho, mx, my, ux, uy, usq, cu, cu2, poly, t, feq, nf;
    result_bits_t res;
    one = longint'(1) << lbm_pkg::FRAC_BITS;
    res = '0;
    rho = 0;
    mx = 0;
    my = 0;
    for (int q = 0; q < lbm_pkg::NDIR; q++) begin
      f[q] = longint'($signed(pops[q*32 +: 32]));
    end
    if (solid) begin
      for (int q = 0; q < lbm_pkg::NDIR; q++) res[q*32 +: 32] = f[q][31:0];
      res[9*32 +: 32] = clamp32(one);
    end else begin
      for (int q = 0; q < lbm_pkg::NDIR; q++) begin
        rho += f[q];
        mx += f[q] * lbm_pkg::DIR_X[q];
        my += f[q] * lbm_pkg::DIR_Y[q];
      end
      rho = clamp32(rho);
      mx = clamp32(mx);
      my = clamp32(my);
      ux = fx_div(mx, rho);
      uy = fx_div(my, rho);
      usq = clamp32(fx_mul(ux, ux) + fx_mul(uy, uy));
      for (int q = 0; q < lbm_pkg::NDIR; q++) begin
        cu = clamp32(lbm_pkg::DIR_X[q] * ux + lbm_pkg::DIR_Y[q] * uy);
        cu2 = clamp32(fx_mul(cu, cu));
        poly = clamp32(one + 3 * cu + fdiv(9 * cu2, 2) - fdiv(3 * usq, 2));
        t = clamp32(fx_mul(rho, poly));
        if (q == 0) feq = fdiv(4 * t, 9);
        else if (q < 5) feq = fdiv(t, 9);
        else feq = fdiv(t, 36);
        nf = clamp32(f[q] + ((longint'(relax_rate) * (feq - f[q])) >>> lbm_pkg::FRAC_BITS));
        res[q*32 +: 32] = nf[31:0];
      end
      res[9*32 +: 32] = rho[31:0];
      res[10*32 +: 32] = ux[31:0];
      res[11*32 +: 32] = uy[31:0];
    end
    pending_results.push_back(res);
  endfunction

  // Compare one output word field by field with the oldest expectation
  function void check_result(input result_bits_t got);
    result_bits_t exp_res;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, got);
      errors++;
      return;
    end
    exp_res = pending_results.pop_front();
    for (int k = 0; k < lbm_pkg::NDIR + 3; k++) begin
      if (got[k*32 +: 32] !== exp_res[k*32 +: 32]) begin
        $display("%0t: field %0d mismatch, expected %h, actual %h", $time, k,
                 exp_res[k*32 +: 32], got[k*32 +: 32]);
        errors++;
      end
    end
  endfunction
endclass

module d2q9_bgk_cell_collision_test;
  import lbm_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam int W_REST = 119304647;
  localparam int W_AXIS = 29826161;
  localparam int W_DIAG = 7456540;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [NDIR*32-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [(NDIR+3)*32-1:0] out_tdata;

  collision_scoreboard sb = new();
  bit quiet = 1'b0;

  d2q9_bgk_cell_collision i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result side at random, except during the quiet stretch
  always @(posedge clk) begin
    out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 23);
    if (out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Send one cell word and hold it until accepted, idling at random afterward
  task automatic send_cell(input logic [NDIR*32-1:0] pops, input logic solid);
    in_tdata <= pops;
    in_tuser <= solid;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_cell(pops, solid);
    if (!quiet && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the relaxation rate while the pipeline is empty
  task automatic write_relax(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_relax(v);
  endtask

  function automatic logic [NDIR*32-1:0] fill_pops(input int v);
    logic [NDIR*32-1:0] p;
    for (int q = 0; q < NDIR; q++) p[q*32 +: 32] = v;
    return p;
  endfunction

  // Near-equilibrium cell with random density and drift
  function automatic logic [NDIR*32-1:0] fluid_pops();
    logic [NDIR*32-1:0] p;
    int w, scale, noise;
    scale = $urandom_range(512, 32);
    noise = $urandom_range(1 << 24);
    for (int q = 0; q < NDIR; q++) begin
      w = (q == 0) ? W_REST : (q < 5) ? W_AXIS : W_DIAG;
      p[q*32 +: 32] = int'((longint'(w) * scale) >>> 8) + int'($urandom_range(noise))
                      - noise / 2;
    end
    return p;
  endfunction

  function automatic logic [NDIR*32-1:0] noise_pops();
    logic [NDIR*32-1:0] p;
    for (int q = 0; q < NDIR; q++) p[q*32 +: 32] = $urandom;
    return p;
  endfunction

  task automatic random_phase(input int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 65) send_cell(fluid_pops(), 1'b0);
      else if (r < 85) send_cell(noise_pops(), 1'b0);
      else send_cell($urandom_range(1) ? fluid_pops() : noise_pops(), 1'b1);
    end
  endtask

  task automatic directed_phase();
    logic [NDIR*32-1:0] p;
    send_cell(fill_pops(0), 1'b0);
    send_cell(fill_pops(32'h7fffffff), 1'b0);
    send_cell(fill_pops(32'h80000000), 1'b0);
    send_cell(fill_pops(-1), 1'b0);
    send_cell(fill_pops(32'h7fffffff), 1'b1);
    send_cell(fill_pops(32'h80000000), 1'b1);
    send_cell(noise_pops(), 1'b1);
    // Rest equilibrium at unit density
    p = fill_pops(W_AXIS);
    p[31:0] = W_REST;
    for (int q = 5; q < NDIR; q++) p[q*32 +: 32] = W_DIAG;
    send_cell(p, 1'b0);
    // Zero density with positive, negative and zero x momentum
    p = fill_pops(0); p[1*32 +: 32] = 1000; p[3*32 +: 32] = -1000;
    send_cell(p, 1'b0);
    p = fill_pops(0); p[1*32 +: 32] = -1000; p[3*32 +: 32] = 1000;
    send_cell(p, 1'b0);
    p = fill_pops(0); p[2*32 +: 32] = 5000; p[4*32 +: 32] = -5000;
    send_cell(p, 1'b0);
    // Tiny density with large momentum saturates the quotient
    p = fill_pops(0); p[1*32 +: 32] = 1 << 27; p[3*32 +: 32] = -(1 << 27) + 1;
    send_cell(p, 1'b0);
    p = fill_pops(0); p[2*32 +: 32] = -(1 << 27) + 1; p[4*32 +: 32] = 1 << 27;
    send_cell(p, 1'b0);
    // Negative density
    p = fill_pops(-(1 << 24)); p[1*32 +: 32] = -(1 << 26);
    send_cell(p, 1'b0);
    // Sums that saturate density and momentum
    p = fill_pops(0); p[1*32 +: 32] = 32'h7fffffff; p[5*32 +: 32] = 32'h7fffffff;
    send_cell(p, 1'b0);
    p = fill_pops(0); p[3*32 +: 32] = 32'h80000000; p[7*32 +: 32] = 32'h80000000;
    send_cell(p, 1'b0);
    for (int n = 0; n < 4; n++) send_cell(noise_pops(), 1'b0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_phase();
    write_relax(CFG_W'(134217728));
    directed_phase();
    random_phase(60);
    write_relax('0);
    random_phase(50);
    // Hold the sender until every expected result has come
    wait_drained();
    write_relax({CFG_W{1'b1}});
    directed_phase();
    random_phase(60);
    write_relax(CFG_W'(456340275));
    quiet = 1'b1;
    random_phase(80);
    quiet = 1'b0;
    random_phase(40);
    write_relax(CFG_W'($urandom_range(536870911)));
    random_phase(60);
    write_relax(RELAX_RESET);
    random_phase(50);
    wait_drained();
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("d2q9_bgk_cell_collision_test passed");
    end else begin
      $display("d2q9_bgk_cell_collision_test failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #4000000;
    $display("d2q9_bgk_cell_collision_test failed");
    $finish;
  end
endmodule
